>>> rtl/hmm_scaled_forward_scorer_assert.svh
// Assertion macros shared by the scorer; clk and arst_n come from the using module.
`ifndef HMM_SCALED_FORWARD_SCORER_ASSERT_SVH
`define HMM_SCALED_FORWARD_SCORER_ASSERT_SVH

// Same-cycle implication, off during reset
`define HSFS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off during reset
`define HSFS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hsfs_pkg.sv
package hsfs_pkg;

	// Fixed formats
	localparam int PROB_FRAC_BITS = 16;
	localparam int PROB_W = 17;
	localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;
	localparam int ALPHA_FRAC = 22;
	localparam int ALPHA_W = 24;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;
	localparam int SCORE_W = 40;
	localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
	localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
	localparam int LN2_Q16 = 45426;
	localparam int LN_TAB_W = 16;

	// Defaults for the top level parameters
	localparam int MAX_STATES_DEF = 8;
	localparam int SYMBOL_COUNT_DEF = 256;

	// Port field widths
	localparam int NUM_STATES_W = 4;
	localparam int STATE_IDX_W = 3;
	localparam int SYMBOL_W = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 17;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_NUM_STATES = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MIN_PROB = 1'b1;

	// Operation codes
	typedef enum logic [1:0] {
		OP_LOAD_TRANS = 2'd0,
		OP_LOAD_EMIT  = 2'd1,
		OP_SCORE      = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]             operation;
		logic [STATE_IDX_W-1:0] state_index;
		logic [SYMBOL_W-1:0]    symbol;
		logic [PROB_W-1:0]      recur_value;
		logic [PROB_W-1:0]      next_value;
		logic                   last_symbol;
	} in_word_t;

	typedef struct packed {
		logic signed [SCORE_W-1:0] log_score;
		logic                      saturated;
	} out_word_t;

	// Floored model probabilities for one state and symbol
	typedef struct packed {
		logic [PROB_W-1:0] self_tp;
		logic [PROB_W-1:0] step_tp;
		logic [PROB_W-1:0] recur_emit;
		logic [PROB_W-1:0] next_emit;
	} arc_probs_t;

	function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] v);
		return (v > PROB_ONE) ? PROB_ONE : v;
	endfunction

	// ln(1 + k/16) in Q16
	function automatic logic [LN_TAB_W-1:0] ln_tab(input logic [4:0] k);
		logic [LN_TAB_W-1:0] r;
		unique case (k)
			5'd0:  r = 16'd0;
			5'd1:  r = 16'd3973;
			5'd2:  r = 16'd7719;
			5'd3:  r = 16'd11262;
			5'd4:  r = 16'd14624;
			5'd5:  r = 16'd17821;
			5'd6:  r = 16'd20870;
			5'd7:  r = 16'd23783;
			5'd8:  r = 16'd26573;
			5'd9:  r = 16'd29248;
			5'd10: r = 16'd31818;
			5'd11: r = 16'd34292;
			5'd12: r = 16'd36675;
			5'd13: r = 16'd38975;
			5'd14: r = 16'd41196;
			5'd15: r = 16'd43345;
			5'd16: r = 16'd45426;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/hmm_scaled_forward_scorer.sv
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_stall   | in_word (in_word_t)
//  out     | out of    | out_valid/out_stall | out_word (out_word_t)
//  cfg     | into      | cfg_we              | cfg_index, cfg_data
//
// A load is written as it is taken and leaves the scorer free for the next word. A scored
// symbol runs the per-state read and two-multiply pass over the n states in use, a normalizing
// log of the sum, and the bit-serial divider over the alpha memory.
// Reset clears control and restores alpha, score and flag; model tables start unwritten.
// A result waits in the output register; a last symbol holds until that register is free.
`include "hmm_scaled_forward_scorer_assert.svh"

module hmm_scaled_forward_scorer import hsfs_pkg::*; #(
	parameter int MAX_STATES = MAX_STATES_DEF,
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_word,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int ST_W = $clog2(MAX_STATES);
	localparam int J_W = $clog2(MAX_STATES + 1);
	localparam int SYM_W = $clog2(SYMBOL_COUNT);
	localparam int SYM_IN_N = 1 << SYMBOL_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_A_RD, ST_A_MUL1, ST_A_MUL2, ST_A_WR, ST_LOG_GO, ST_LOG_WAIT,
		ST_B_RD, ST_B_START, ST_B_WAIT, ST_ACC, ST_EMIT
	} state_t;

	state_t                    state_q;
	logic [NUM_STATES_W-1:0]   num_states_q;
	logic [PROB_W-1:0]         min_prob_q;
	logic [J_W-1:0]            n_q;
	logic [J_W-1:0]            j_q;
	logic [SYM_W-1:0]          sym_q;
	logic                      last_q;
	logic                      fresh_q;
	logic [ALPHA_W-1:0]        sum_q;
	logic [ALPHA_W-1:0]        carry_q;
	logic signed [SCORE_W-1:0] acc_q;
	logic signed [SCORE_W-1:0] ln_q;
	logic                      sat_q;
	logic                      out_valid_q;
	out_word_t                 out_word_q;
	logic [ALPHA_W-1:0]        rec_s1, nxt_s1, rec_s2, nxt_s2;

	logic [SYM_W-1:0]          sym_wrap [SYM_IN_N];
	logic [ALPHA_W-1:0]        alpha_mem [MAX_STATES];
	logic [ALPHA_W-1:0]        alpha_rd_q;
	logic                      alpha_we;
	logic [ALPHA_W-1:0]        alpha_wdata;
	logic [ALPHA_W-1:0]        alpha_cur;
	logic [ALPHA_W-1:0]        nw;

	logic                      in_acc;
	logic                      is_load;
	logic                      st_ok;
	logic [J_W-1:0]            n_eff;
	logic [PROB_W-1:0]         floor_prob;
	arc_probs_t                probs;
	logic                      sum_zero;
	logic                      div_need;
	logic                      div_done;
	logic [ALPHA_W-1:0]        div_quot;
	logic                      log_done;
	logic signed [SCORE_W-1:0] log_ln;
	logic signed [SCORE_W:0]   acc_sum;
	logic                      out_free;
	logic [ALPHA_W+PROB_W-1:0] prod_rt, prod_nt, prod_re, prod_ne;

	// Symbol wrap table
	for (genvar g = 0; g < SYM_IN_N; g++) begin : g_wrap
		assign sym_wrap[g] = SYM_W'(g % SYMBOL_COUNT);
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid & ~in_stall;
	assign is_load = (in_word.operation == OP_LOAD_TRANS) || (in_word.operation == OP_LOAD_EMIT);
	assign st_ok = int'(in_word.state_index) < MAX_STATES;
	assign floor_prob = clamp_prob(min_prob_q);
	assign sum_zero = (sum_q == '0);
	assign out_free = ~out_valid_q | ~out_stall;

	always_comb begin
		if (num_states_q == '0)
			n_eff = J_W'(1);
		else if (int'(num_states_q) > MAX_STATES)
			n_eff = J_W'(MAX_STATES);
		else
			n_eff = J_W'(num_states_q);
	end

	hsfs_tables #(
		.MAX_STATES  (MAX_STATES),
		.SYMBOL_COUNT(SYMBOL_COUNT)
	) u_tables (
		.clk       (clk),
		.trans_we  (in_acc && in_word.operation == OP_LOAD_TRANS && st_ok),
		.emit_we   (in_acc && in_word.operation == OP_LOAD_EMIT && st_ok),
		.wr_state  (ST_W'(in_word.state_index)),
		.wr_sym    (sym_wrap[in_word.symbol]),
		.wr_recur  (clamp_prob(in_word.recur_value)),
		.wr_next   (clamp_prob(in_word.next_value)),
		.rd_state  (j_q[ST_W-1:0]),
		.rd_sym    (sym_q),
		.floor_prob(floor_prob),
		.probs     (probs)
	);

	// Alpha read, with the restart vector standing in until the first divide pass
	assign alpha_cur = fresh_q ? ((j_q == '0) ? ALPHA_ONE : '0) : alpha_rd_q;

	// Arc products
	always_comb begin
		prod_rt = (ALPHA_W+PROB_W)'(alpha_cur) * (ALPHA_W+PROB_W)'(probs.self_tp);
		prod_nt = (ALPHA_W+PROB_W)'(alpha_cur) * (ALPHA_W+PROB_W)'(probs.step_tp);
		prod_re = (ALPHA_W+PROB_W)'(rec_s1) * (ALPHA_W+PROB_W)'(probs.recur_emit);
		prod_ne = (ALPHA_W+PROB_W)'(nxt_s1) * (ALPHA_W+PROB_W)'(probs.next_emit);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_A_MUL1) begin
			rec_s1 <= prod_rt[PROB_FRAC_BITS +: ALPHA_W];
			nxt_s1 <= prod_nt[PROB_FRAC_BITS +: ALPHA_W];
		end
		if (state_q == ST_A_MUL2) begin
			rec_s2 <= prod_re[PROB_FRAC_BITS +: ALPHA_W];
			nxt_s2 <= prod_ne[PROB_FRAC_BITS +: ALPHA_W];
		end
	end

	// New entry: own self-loop term plus the carried next term of the state before
	assign nw = rec_s2 + carry_q;
	assign div_need = (j_q < n_q) && !sum_zero;

	always_comb begin
		alpha_we = 1'b0;
		alpha_wdata = '0;
		unique case (state_q)
			ST_A_WR: begin
				alpha_we = 1'b1;
				alpha_wdata = nw;
			end
			ST_B_START: alpha_we = !div_need;
			ST_B_WAIT: begin
				alpha_we = div_done;
				alpha_wdata = div_quot;
			end
			default: alpha_we = 1'b0;
		endcase
	end

	// Alpha memory: one write, one registered read at the step index
	always_ff @(posedge clk) begin
		if (alpha_we)
			alpha_mem[j_q[ST_W-1:0]] <= alpha_wdata;
		alpha_rd_q <= alpha_mem[j_q[ST_W-1:0]];
	end

	hsfs_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_B_START && div_need),
		.num   (alpha_rd_q),
		.den   (sum_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	hsfs_log u_log (
		.clk   (clk),
		.arst_n(arst_n),
		.start (state_q == ST_LOG_GO && !sum_zero),
		.sum   (sum_q),
		.done  (log_done),
		.ln    (log_ln)
	);

	assign acc_sum = {acc_q[SCORE_W-1], acc_q} + {ln_q[SCORE_W-1], ln_q};

	// Sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			num_states_q <= NUM_STATES_W'(3);
			min_prob_q <= PROB_W'(1);
			n_q <= '0;
			j_q <= '0;
			sym_q <= '0;
			last_q <= 1'b0;
			fresh_q <= 1'b1;
			sum_q <= '0;
			carry_q <= '0;
			acc_q <= '0;
			ln_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_word_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_NUM_STATES: num_states_q <= cfg_data[NUM_STATES_W-1:0];
					CFG_MIN_PROB:   min_prob_q <= cfg_data[PROB_W-1:0];
					default:        min_prob_q <= min_prob_q;
				endcase
			end
			// Load a result word on emit, drop it once taken
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && !is_load && in_word.operation == OP_SCORE) begin
						n_q <= n_eff;
						j_q <= '0;
						sym_q <= sym_wrap[in_word.symbol];
						last_q <= in_word.last_symbol;
						sum_q <= '0;
						carry_q <= '0;
						state_q <= ST_A_RD;
					end
				end
				ST_A_RD:   state_q <= ST_A_MUL1;
				ST_A_MUL1: state_q <= ST_A_MUL2;
				ST_A_MUL2: state_q <= ST_A_WR;
				ST_A_WR: begin
					sum_q <= sum_q + nw;
					carry_q <= nxt_s2;
					if (j_q + 1'b1 == n_q) begin
						state_q <= ST_LOG_GO;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= ST_A_RD;
					end
				end
				ST_LOG_GO: begin
					fresh_q <= 1'b0;
					j_q <= '0;
					state_q <= sum_zero ? ST_B_RD : ST_LOG_WAIT;
				end
				ST_LOG_WAIT: begin
					if (log_done) begin
						ln_q <= log_ln;
						state_q <= ST_B_RD;
					end
				end
				ST_B_RD: state_q <= ST_B_START;
				ST_B_START, ST_B_WAIT: begin
					if ((state_q == ST_B_START && !div_need) ||
					    (state_q == ST_B_WAIT && div_done)) begin
						if (j_q == J_W'(MAX_STATES - 1)) begin
							state_q <= ST_ACC;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= ST_B_RD;
						end
					end else begin
						state_q <= ST_B_WAIT;
					end
				end
				ST_ACC: begin
					if (sum_zero) begin
						acc_q <= SCORE_MIN;
						sat_q <= 1'b1;
					end else if (acc_sum[SCORE_W] != acc_sum[SCORE_W-1]) begin
						acc_q <= acc_sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
						sat_q <= 1'b1;
					end else begin
						acc_q <= acc_sum[SCORE_W-1:0];
					end
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_word_q.log_score <= acc_q;
						out_word_q.saturated <= sat_q;
						acc_q <= '0;
						sat_q <= 1'b0;
						fresh_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	`HSFS_ASSERT_IMPL(a_div_done_in_wait, div_done, state_q == ST_B_WAIT, "divider finished outside the divide pass")
	`HSFS_ASSERT_IMPL(a_fresh_not_in_divide, fresh_q, (state_q != ST_B_RD && state_q != ST_B_START && state_q != ST_B_WAIT), "restart vector active during divide pass")
	`HSFS_ASSERT_NEXT(a_emit_loads_output, (state_q == ST_EMIT && out_free), out_valid && fresh_q && state_q == ST_IDLE, "result not loaded on emit")

endmodule

>>> rtl/hsfs_tables.sv
module hsfs_tables import hsfs_pkg::*; #(
	parameter int MAX_STATES = MAX_STATES_DEF,
	parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
	localparam int ST_W = $clog2(MAX_STATES),
	localparam int SYM_W = $clog2(SYMBOL_COUNT)
) (
	input  logic              clk,
	input  logic              trans_we,
	input  logic              emit_we,
	input  logic [ST_W-1:0]   wr_state,
	input  logic [SYM_W-1:0]  wr_sym,
	input  logic [PROB_W-1:0] wr_recur,
	input  logic [PROB_W-1:0] wr_next,
	input  logic [ST_W-1:0]   rd_state,
	input  logic [SYM_W-1:0]  rd_sym,
	input  logic [PROB_W-1:0] floor_prob,
	output arc_probs_t        probs
);

	localparam int EMIT_DEPTH = MAX_STATES * SYMBOL_COUNT;
	localparam int EA_W = $clog2(EMIT_DEPTH);

	logic [2*PROB_W-1:0] trans_mem [MAX_STATES];
	logic [2*PROB_W-1:0] emit_mem [EMIT_DEPTH];
	logic [2*PROB_W-1:0] trans_rd_q;
	logic [2*PROB_W-1:0] emit_rd_q;
	logic [EA_W-1:0]     wr_addr;
	logic [EA_W-1:0]     rd_addr;

	// Row per state, column per symbol
	assign wr_addr = EA_W'(wr_state) * EA_W'(SYMBOL_COUNT) + EA_W'(wr_sym);
	assign rd_addr = EA_W'(rd_state) * EA_W'(SYMBOL_COUNT) + EA_W'(rd_sym);

	// Write loads, registered read
	always_ff @(posedge clk) begin
		if (trans_we)
			trans_mem[wr_state] <= {wr_recur, wr_next};
		if (emit_we)
			emit_mem[wr_addr] <= {wr_recur, wr_next};
		trans_rd_q <= trans_mem[rd_state];
		emit_rd_q <= emit_mem[rd_addr];
	end

	function automatic logic [PROB_W-1:0] floored(input logic [PROB_W-1:0] v,
			input logic [PROB_W-1:0] f);
		return (v < f) ? f : v;
	endfunction

	// Apply the probability floor on every read
	always_comb begin
		probs.self_tp = floored(trans_rd_q[2*PROB_W-1:PROB_W], floor_prob);
		probs.step_tp = floored(trans_rd_q[PROB_W-1:0], floor_prob);
		probs.recur_emit = floored(emit_rd_q[2*PROB_W-1:PROB_W], floor_prob);
		probs.next_emit = floored(emit_rd_q[PROB_W-1:0], floor_prob);
	end

endmodule

>>> rtl/hsfs_divider.sv
module hsfs_divider import hsfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ALPHA_W-1:0] num,
	input  logic [ALPHA_W-1:0] den,
	output logic               done,
	output logic [ALPHA_W-1:0] quot
);

	// (num << ALPHA_FRAC) / den with num < 2 * den: one quotient bit per cycle
	localparam int Q_W = ALPHA_FRAC + 1;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [ALPHA_W-1:0] rem_q;
	logic [Q_W-1:0]     dlo_q;
	logic [Q_W-1:0]     quot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [ALPHA_W:0]   trial;
	logic               fits;

	assign trial = {rem_q, dlo_q[Q_W-1]};
	assign fits = trial >= {1'b0, den};

	// Count iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num >> 1;
			dlo_q <= {num[0], {ALPHA_FRAC{1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? ALPHA_W'(trial - {1'b0, den}) : ALPHA_W'(trial);
			dlo_q <= dlo_q << 1;
			quot_q <= {quot_q[Q_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = ALPHA_W'(quot_q);

endmodule

>>> rtl/hsfs_log.sv
module hsfs_log import hsfs_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ALPHA_W-1:0]        sum,
	output logic                      done,
	output logic signed [SCORE_W-1:0] ln
);

	logic [31:0]               norm_q;
	logic [4:0]                msb_q;
	logic                      busy_q;
	logic                      done_q;
	logic signed [SCORE_W-1:0] ln_q;
	logic [3:0]                idx;
	logic [15:0]               frac;
	logic [LN_TAB_W-1:0]       t0;
	logic [LN_TAB_W-1:0]       t1;
	logic [31:0]               interp;
	logic signed [6:0]         expo;
	logic signed [SCORE_W-1:0] ln_v;

	// Table lookup with linear interpolation on the normalized mantissa
	always_comb begin
		idx = norm_q[30:27];
		frac = norm_q[26:11];
		t0 = ln_tab({1'b0, idx});
		t1 = ln_tab({1'b0, idx} + 5'd1);
		interp = (32'(t1 - t0) * 32'(frac)) >> 16;
		expo = $signed({2'b00, msb_q}) - 7'sd22;
		ln_v = SCORE_W'(expo) * $signed(SCORE_W'(LN2_Q16))
			+ $signed(SCORE_W'(t0)) + $signed(SCORE_W'(interp[15:0]));
	end

	// Normalize one bit a cycle, then register the log
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && norm_q[31]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			norm_q <= 32'(sum);
			msb_q <= 5'd31;
		end else if (busy_q) begin
			if (norm_q[31]) begin
				ln_q <= ln_v;
			end else begin
				norm_q <= norm_q << 1;
				msb_q <= msb_q - 5'd1;
			end
		end
	end

	assign done = done_q;
	assign ln = ln_q;

endmodule

>>> tb/tb.sv
module tb;
	import hsfs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS = 470;
	localparam logic [1:0] OP_UNDEF = 2'd3;
	localparam logic [PROB_W-1:0] PROB_FULL = '1;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_word_t in_word;
	logic out_valid;
	logic out_stall;
	out_word_t out_word;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hmm_scaled_forward_scorer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Scorer shadow state
	bit [NUM_STATES_W-1:0] m_states;
	bit [PROB_W-1:0] m_floor;
	bit [PROB_W-1:0] m_rtrans [8];
	bit [PROB_W-1:0] m_ntrans [8];
	bit [PROB_W-1:0] m_remit [8][256];
	bit [PROB_W-1:0] m_nemit [8][256];
	bit [ALPHA_W-1:0] m_alpha [8];
	longint m_acc;
	bit m_sat;
	longint m_lntab [17] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
		29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426};

	out_word_t scores_due [$];
	bit [SYMBOL_W-1:0] full_syms [$];
	int send_idle;
	int recv_idle;
	int errors;
	int quiet;
	int phase_items;

	typedef struct {
		bit is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
		in_word_t w;
		bit typed;
		out_word_t want;
	} row_t;
	row_t rows [$];

	function automatic bit [PROB_W-1:0] clip(bit [PROB_W-1:0] v);
		return (v > PROB_ONE) ? PROB_ONE : v;
	endfunction

	function automatic longint unsigned floor_read(bit [PROB_W-1:0] v);
		bit [PROB_W-1:0] f;
		f = clip(m_floor);
		return (v < f) ? f : v;
	endfunction

	function automatic longint unsigned arc(longint unsigned a, bit [PROB_W-1:0] t,
		bit [PROB_W-1:0] e);
		longint unsigned x;
		x = (a * floor_read(t)) >> PROB_FRAC_BITS;
		return (x * floor_read(e)) >> PROB_FRAC_BITS;
	endfunction

	function automatic longint ln_fixed(longint unsigned s);
		int m;
		longint unsigned mant;
		longint unsigned idx;
		longint unsigned frac;
		m = 0;
		for (int b = 0; b < 32; b++)
			if (s[b]) m = b;
		mant = (s << (31 - m)) & 64'hFFFF_FFFF;
		idx = (mant >> 27) & 15;
		frac = (mant >> 11) & 16'hFFFF;
		return longint'(m - ALPHA_FRAC) * LN2_Q16 + m_lntab[idx] +
			longint'((unsigned'(m_lntab[idx + 1] - m_lntab[idx]) * frac) >> 16);
	endfunction

	function automatic void restart_string();
		foreach (m_alpha[j]) m_alpha[j] = '0;
		m_alpha[0] = ALPHA_ONE;
		m_acc = 0;
		m_sat = 1'b0;
	endfunction

	// Advance the shadow scorer by one word; return 1 when a score is due
	function automatic bit score_word(in_word_t w, output out_word_t r);
		longint unsigned nw [8];
		longint unsigned s;
		int n;
		int sym;
		longint acc;
		sym = w.symbol;
		r = '0;
		if (w.operation == OP_LOAD_TRANS) begin
			m_rtrans[w.state_index] = clip(w.recur_value);
			m_ntrans[w.state_index] = clip(w.next_value);
			return 1'b0;
		end
		if (w.operation == OP_LOAD_EMIT) begin
			m_remit[w.state_index][sym] = clip(w.recur_value);
			m_nemit[w.state_index][sym] = clip(w.next_value);
			return 1'b0;
		end
		if (w.operation != OP_SCORE) return 1'b0;
		n = m_states;
		if (n < 1) n = 1;
		if (n > 8) n = 8;
		foreach (nw[j]) nw[j] = 0;
		for (int j = n - 1; j > 0; j--)
			nw[j] = arc(m_alpha[j], m_rtrans[j], m_remit[j][sym]) +
				arc(m_alpha[j - 1], m_ntrans[j - 1], m_nemit[j - 1][sym]);
		nw[0] = arc(m_alpha[0], m_rtrans[0], m_remit[0][sym]);
		s = 0;
		for (int j = 0; j < n; j++) s += nw[j];
		if (s == 0) begin
			foreach (m_alpha[j]) m_alpha[j] = '0;
			m_acc = longint'(SCORE_MIN);
			m_sat = 1'b1;
		end else begin
			for (int j = 0; j < 8; j++)
				m_alpha[j] = (j < n) ? ALPHA_W'((nw[j] << ALPHA_FRAC) / s) : '0;
			acc = m_acc + ln_fixed(s);
			if (acc > longint'(SCORE_MAX)) begin
				acc = longint'(SCORE_MAX);
				m_sat = 1'b1;
			end else if (acc < longint'(SCORE_MIN)) begin
				acc = longint'(SCORE_MIN);
				m_sat = 1'b1;
			end
			m_acc = acc;
		end
		if (!w.last_symbol) return 1'b0;
		r.log_score = SCORE_W'(m_acc);
		r.saturated = m_sat;
		restart_string();
		return 1'b1;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Send one word, then update the shadow scorer once it is taken
	task automatic send_word(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
		out_word_t r;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (score_word(w, r)) scores_due.push_back(typed ? want : r);
		if (w.operation != OP_UNDEF) phase_items++;
	endtask

	// Drain results and let a pending non-final symbol finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (scores_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NUM_STATES) m_states = data[NUM_STATES_W-1:0];
		else m_floor = data;
		@(posedge clk);
	endtask

	function automatic in_word_t mk(logic [1:0] op, int st, int sym, int rv, int nv, bit last);
		in_word_t w;
		w.operation = op;
		w.state_index = STATE_IDX_W'(st);
		w.symbol = SYMBOL_W'(sym);
		w.recur_value = PROB_W'(rv);
		w.next_value = PROB_W'(nv);
		w.last_symbol = last;
		return w;
	endfunction

	function automatic void add_item(in_word_t w, bit typed = 1'b0, out_word_t want = '0);
		row_t r;
		r.is_cfg = 1'b0;
		r.w = w;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endfunction

	function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, int data);
		row_t r;
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.data = CFG_DATA_W'(data);
		r.typed = 1'b0;
		rows.push_back(r);
	endfunction

	function automatic int rand_prob();
		case ($urandom_range(9))
			0: return 0;
			1: return PROB_ONE;
			2: return PROB_FULL;
			3: return $urandom_range(PROB_FULL);
			default: return $urandom_range(65536, 20000);
		endcase
	endfunction

	function automatic int pick_states();
		case ($urandom_range(5))
			0: return 0;
			1: return 1;
			2: return 8;
			3: return 15;
			default: return $urandom_range(15);
		endcase
	endfunction

	function automatic int pick_floor();
		case ($urandom_range(6))
			0: return 0;
			1: return 1;
			2: return PROB_ONE;
			3: return PROB_FULL;
			4: return $urandom_range(PROB_FULL);
			default: return $urandom_range(3000);
		endcase
	endfunction

	// Fill one emission column for every state
	task automatic load_column();
		int sym;
		sym = $urandom_range(255);
		for (int st = 0; st < 8; st++)
			send_word(mk(OP_LOAD_EMIT, st, sym, rand_prob(), rand_prob(), $urandom_range(1)));
		full_syms.push_back(SYMBOL_W'(sym));
	endtask

	// One stretch of random traffic under one register setting
	task automatic run_stretch();
		int len;
		int stop;
		settle();
		write_reg(CFG_NUM_STATES, CFG_DATA_W'(pick_states()));
		write_reg(CFG_MIN_PROB, CFG_DATA_W'(pick_floor()));
		if (full_syms.size() == 0) load_column();
		stop = phase_items + 40;
		while (phase_items < stop) begin
			case ($urandom_range(19))
				0, 1, 2: load_column();
				3: send_word(mk(OP_LOAD_TRANS, $urandom_range(7), $urandom_range(255),
					rand_prob(), rand_prob(), $urandom_range(1)));
				4: send_word(mk(OP_UNDEF, $urandom_range(7), $urandom_range(255),
					$urandom_range(PROB_FULL), $urandom_range(PROB_FULL), $urandom_range(1)));
				default: begin
					len = $urandom_range(6, 1);
					for (int k = 0; k < len; k++)
						send_word(mk(OP_SCORE, $urandom_range(7),
							full_syms[$urandom_range(full_syms.size() - 1)],
							$urandom_range(PROB_FULL), $urandom_range(PROB_FULL), k == len - 1));
				end
			endcase
		end
	endtask

	// Receiver stall, result check and watchdog
	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
			quiet <= 0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
			else quiet <= quiet + 1;
			if (out_valid && !out_stall) begin
				if (scores_due.size() == 0) begin
					$error("unexpected score word: log_score %0d saturated %0b",
						out_word.log_score, out_word.saturated);
					errors++;
				end else begin
					e = scores_due.pop_front();
					if (out_word.log_score !== e.log_score) begin
						$error("log_score: expected %0d, got %0d", e.log_score,
							out_word.log_score);
						errors++;
					end
					if (out_word.saturated !== e.saturated) begin
						$error("saturated: expected %0b, got %0b", e.saturated,
							out_word.saturated);
						errors++;
					end
				end
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		out_word_t w0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		errors = 0;
		phase_items = 0;
		send_idle = 37;
		recv_idle = 58;
		m_states = 3;
		m_floor = 1;
		restart_string();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero sum, full floor, single state, ignored opcode, clamped values
		add_cfg(CFG_MIN_PROB, 0);
		add_item(mk(OP_LOAD_TRANS, 0, 0, 0, 0, 1'b0));
		add_item(mk(OP_LOAD_TRANS, 1, 0, PROB_FULL, PROB_ONE, 1'b1));
		add_item(mk(OP_LOAD_TRANS, 2, 0, PROB_ONE, 0, 1'b0));
		for (int st = 0; st < 3; st++) add_item(mk(OP_LOAD_EMIT, st, 0, 0, 0, 1'b0));
		w0.log_score = SCORE_MIN;
		w0.saturated = 1'b1;
		add_item(mk(OP_SCORE, 0, 0, 0, 0, 1'b1), 1'b1, w0);
		add_cfg(CFG_MIN_PROB, PROB_FULL);
		w0.log_score = SCORE_W'(LN2_Q16);
		w0.saturated = 1'b0;
		add_item(mk(OP_SCORE, 7, 0, PROB_FULL, PROB_FULL, 1'b1), 1'b1, w0);
		for (int st = 0; st < 3; st++)
			add_item(mk(OP_LOAD_EMIT, st, 255, PROB_FULL, 12345, 1'b1));
		add_cfg(CFG_NUM_STATES, 1);
		w0.log_score = '0;
		add_item(mk(OP_SCORE, 0, 255, 0, 0, 1'b1), 1'b1, w0);
		add_item(mk(OP_UNDEF, 7, 255, PROB_FULL, PROB_FULL, 1'b1));
		add_cfg(CFG_NUM_STATES, 0);
		add_cfg(CFG_MIN_PROB, 1);
		add_item(mk(OP_SCORE, 0, 0, 0, 0, 1'b0));
		add_item(mk(OP_SCORE, 0, 255, 0, 0, 1'b1));
		for (int st = 3; st < 8; st++)
			add_item(mk(OP_LOAD_TRANS, st, 0, 50000 + st, PROB_FULL, 1'b0));
		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				settle();
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				send_word(rows[i].w, rows[i].typed, rows[i].want);
			end
		end

		// Random: three idling patterns, register setting changed per stretch
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 37 : (ph == 1) ? 58 : 0;
			recv_idle = (ph == 0) ? 58 : (ph == 1) ? 37 : 0;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) run_stretch();
		end

		settle();
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
